>>> rtl/lzgd_pkg.sv
// ----------------------------------------------------------------------------
// lzgd_pkg
// Shared types and constants for the tag-bit and gamma-length LZ depacker.
// ----------------------------------------------------------------------------
package lzgd_pkg;

   localparam int HISTORY_DEPTH_DEF = 65536;
   localparam int MAX_BURST_DEF     = 64;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [31:0] OFF_FAR    = 32'd32000;
   localparam logic [31:0] OFF_MID    = 32'd1280;
   localparam logic [31:0] OFF_NEAR   = 32'd128;
   localparam logic [31:0] TOTAL_MAX  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_BYTE   = 2'd0,
      ACT_RESUME = 2'd1,
      ACT_START  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_NEED  = 2'd0,
      ST_PAUSE = 2'd1,
      ST_END   = 2'd2,
      ST_ERR   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_FIRST   = 5'd0,
      PH_LIT     = 5'd1,
      PH_OFFBYTE = 5'd2,
      PH_SHORT   = 5'd3,
      PH_T0      = 5'd4,
      PH_T1      = 5'd5,
      PH_T2      = 5'd6,
      PH_M1V     = 5'd7,
      PH_M1C     = 5'd8,
      PH_MLV     = 5'd9,
      PH_MLC     = 5'd10,
      PH_RLV     = 5'd11,
      PH_RLC     = 5'd12,
      PH_NIB     = 5'd13,
      PH_COPY    = 5'd14,
      PH_HOLD    = 5'd15,
      PH_END     = 5'd16,
      PH_ERR     = 5'd17
   } phase_type;

   typedef enum logic [2:0] {
      ES_IDLE = 3'd0,
      ES_TAKE = 3'd1,
      ES_RUN  = 3'd2,
      ES_READ = 3'd3,
      ES_DONE = 3'd4
   } eng_state_type;

   typedef enum logic [1:0] {
      MS_IDLE = 2'd0,
      MS_READ = 2'd1,
      MS_SHOW = 2'd2
   } emit_state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [31:0] total;
   } hand_type;

   function automatic status_type phase_status(input phase_type ph);
      status_type st;
      case (ph)
         PH_END:  st = ST_END;
         PH_ERR:  st = ST_ERR;
         PH_COPY: st = ST_PAUSE;
         PH_HOLD: st = ST_PAUSE;
         default: st = ST_NEED;
      endcase
      return st;
   endfunction

endpackage

>>> rtl/lzgd_front.sv
// ----------------------------------------------------------------------------
// lzgd_front
// Input queue that accepts transactions and holds them for the decoder.
// ----------------------------------------------------------------------------
module lzgd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [7:0]        req_data_byte,
   output logic              item_valid,
   output lzgd_pkg::item_type item,
   input  logic              item_pop
);
   import lzgd_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            push, pop;

   assign req_ready  = (fill_ff != CW'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign pop        = item_pop && item_valid;
   assign item_valid = (fill_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{action: req_action, data_byte: req_data_byte};
      end
   end

endmodule

>>> rtl/lzgd_engine.sv
// ----------------------------------------------------------------------------
// lzgd_engine
// Decoder that steps one tag bit per cycle within a transaction, reads the
// history for copied and nibble bytes, and keeps the history memory.
// ----------------------------------------------------------------------------
module lzgd_engine #(
   parameter int HISTORY_DEPTH = lzgd_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_BURST     = lzgd_pkg::MAX_BURST_DEF,
   parameter int CW            = $clog2(MAX_BURST + 1),
   parameter int BW            = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  lzgd_pkg::item_type item,
   output logic               item_pop,
   input  logic               emit_busy,
   output lzgd_pkg::hand_type hand,
   output logic [CW-1:0]      hand_count,
   output logic               bw_en,
   output logic [BW-1:0]      bw_addr,
   output logic [7:0]         bw_byte,
   output logic [31:0]        bw_total
);
   import lzgd_pkg::*;

   localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int OFF_W = $clog2(HISTORY_DEPTH) + 1;
   localparam logic [OFF_W-1:0] DEPTH_O = OFF_W'(HISTORY_DEPTH);

   eng_state_type est_ff, est_in;
   phase_type     phase_ff, phase_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [31:0]      wt_ff, wt_in, wt_next;
   logic [7:0]       tag_ff, tag_in;
   logic [3:0]       tbi_ff, tbi_in;
   logic             amf_ff, amf_in;
   logic [OFF_W-1:0] loff_ff, loff_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      crem_ff, crem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [1:0]       act_ff, act_in;
   logic [7:0]       byte_ff, byte_in;

   logic [7:0]       hist_mem [HISTORY_DEPTH];
   logic [7:0]       hist_q;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             emit_en;
   logic [7:0]       emit_val;
   logic             bit_v;
   logic [31:0]      acc_sh, g;
   logic [33:0]      mlen;
   logic [39:0]      off_wide;
   logic [6:0]       soff;
   logic [3:0]       noff;
   logic             paused, done, burst_full;

   function automatic logic off_ok(input logic [39:0] off, input logic [31:0] wt);
      return (off != '0) && (off <= {8'd0, wt}) && (off <= 40'(HISTORY_DEPTH));
   endfunction

   function automatic logic [AW-1:0] hist_idx(input logic [AW-1:0] wp,
                                              input logic [OFF_W-1:0] off);
      logic [OFF_W-1:0] wpx, r;
      wpx = OFF_W'(wp);
      if (wpx >= off) begin
         r = wpx - off;
      end else begin
         r = wpx + DEPTH_O - off;
      end
      return r[AW-1:0];
   endfunction

   assign paused     = (phase_ff == PH_COPY) || (phase_ff == PH_HOLD);
   assign done       = (phase_ff == PH_END) || (phase_ff == PH_ERR);
   assign burst_full = (cnt_ff >= CW'(MAX_BURST));
   assign bit_v      = tag_ff[3'd7 - tbi_ff[2:0]];
   assign acc_sh     = {acc_ff[30:0], bit_v};
   assign wt_next    = (wt_ff == TOTAL_MAX) ? wt_ff : wt_ff + 32'd1;

   always_comb begin
      est_in   = est_ff;
      phase_in = phase_ff;
      wp_in    = wp_ff;
      wt_in    = wt_ff;
      tag_in   = tag_ff;
      tbi_in   = tbi_ff;
      amf_in   = amf_ff;
      loff_in  = loff_ff;
      acc_in   = acc_ff;
      crem_in  = crem_ff;
      cnt_in   = cnt_ff;
      act_in   = act_ff;
      byte_in  = byte_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      emit_en  = 1'b0;
      emit_val = '0;
      g        = acc_ff - 32'd2;
      mlen     = 34'(acc_ff);
      off_wide = {acc_ff, byte_ff};
      soff     = byte_ff[7:1];
      noff     = acc_sh[3:0];
      case (est_ff)
         ES_IDLE: begin
            if (item_valid && !emit_busy) begin
               act_in  = item.action;
               byte_in = item.data_byte;
               cnt_in  = '0;
               if (item.action == ACT_START) begin
                  phase_in = PH_FIRST;
                  wp_in    = '0;
                  wt_in    = '0;
                  tag_in   = '0;
                  tbi_in   = 4'd8;
                  amf_in   = 1'b0;
                  loff_in  = '0;
                  acc_in   = '0;
                  crem_in  = '0;
                  est_in   = ES_DONE;
               end else if (done) begin
                  est_in = ES_DONE;
               end else if (item.action == ACT_BYTE && !paused) begin
                  est_in = ES_TAKE;
               end else if (item.action == ACT_RESUME && paused) begin
                  if (phase_ff == PH_HOLD) begin
                     phase_in = PH_T0;
                  end
                  est_in = ES_RUN;
               end else begin
                  est_in = ES_DONE;
               end
            end
         end
         ES_TAKE: begin
            est_in = ES_RUN;
            case (phase_ff)
               PH_FIRST, PH_LIT: begin
                  emit_en  = 1'b1;
                  emit_val = byte_ff;
                  amf_in   = 1'b0;
                  phase_in = PH_T0;
               end
               PH_OFFBYTE: begin
                  if (!off_ok(off_wide, wt_ff)) begin
                     phase_in = PH_ERR;
                  end else begin
                     loff_in  = off_wide[OFF_W-1:0];
                     acc_in   = 32'd1;
                     phase_in = PH_MLV;
                  end
               end
               PH_SHORT: begin
                  if (soff == '0) begin
                     phase_in = PH_END;
                  end else if (!off_ok(40'(soff), wt_ff)) begin
                     phase_in = PH_ERR;
                  end else begin
                     loff_in  = OFF_W'(soff);
                     amf_in   = 1'b1;
                     crem_in  = 32'd2 + 32'(byte_ff[0]);
                     phase_in = PH_COPY;
                  end
               end
               PH_T0, PH_T1, PH_T2, PH_M1V, PH_M1C, PH_MLV, PH_MLC,
               PH_RLV, PH_RLC, PH_NIB: begin
                  tag_in = byte_ff;
                  tbi_in = 4'd0;
               end
               default: begin
               end
            endcase
         end
         ES_RUN: begin
            case (phase_ff)
               PH_COPY: begin
                  if (crem_ff != '0 && !burst_full) begin
                     rd_en   = 1'b1;
                     rd_addr = hist_idx(wp_ff, loff_ff);
                     est_in  = ES_READ;
                  end else if (crem_ff != '0) begin
                     est_in = ES_DONE;
                  end else begin
                     phase_in = PH_T0;
                  end
               end
               PH_T0, PH_T1, PH_T2, PH_M1V, PH_M1C, PH_MLV, PH_MLC,
               PH_RLV, PH_RLC, PH_NIB: begin
                  if (tbi_ff[3]) begin
                     est_in = ES_DONE;
                  end else if (phase_ff == PH_T0 && burst_full) begin
                     phase_in = PH_HOLD;
                     est_in   = ES_DONE;
                  end else begin
                     tbi_in = tbi_ff + 4'd1;
                     case (phase_ff)
                        PH_T0: phase_in = bit_v ? PH_T1 : PH_LIT;
                        PH_T1: begin
                           if (bit_v) begin
                              phase_in = PH_T2;
                           end else begin
                              acc_in   = 32'd1;
                              phase_in = PH_M1V;
                           end
                        end
                        PH_T2: begin
                           if (bit_v) begin
                              acc_in   = 32'd1;
                              phase_in = PH_NIB;
                           end else begin
                              phase_in = PH_SHORT;
                           end
                        end
                        PH_M1V, PH_MLV, PH_RLV: begin
                           if (acc_ff[31]) begin
                              phase_in = PH_ERR;
                              est_in   = ES_DONE;
                           end else begin
                              acc_in   = acc_sh;
                              phase_in = phase_type'(phase_ff + 5'd1);
                           end
                        end
                        PH_M1C, PH_MLC, PH_RLC: begin
                           if (bit_v) begin
                              phase_in = phase_type'(phase_ff - 5'd1);
                           end else if (phase_ff == PH_M1C) begin
                              if (!amf_ff) begin
                                 amf_in = 1'b1;
                                 if (g == '0) begin
                                    acc_in   = 32'd1;
                                    phase_in = PH_RLV;
                                 end else begin
                                    acc_in   = g - 32'd1;
                                    phase_in = PH_OFFBYTE;
                                 end
                              end else begin
                                 acc_in   = g;
                                 phase_in = PH_OFFBYTE;
                              end
                           end else if (phase_ff == PH_MLC) begin
                              mlen = 34'(acc_ff)
                                   + 34'(32'(loff_ff) >= OFF_FAR)
                                   + 34'(32'(loff_ff) >= OFF_MID)
                                   + ((32'(loff_ff) < OFF_NEAR) ? 34'd2 : 34'd0);
                              if (mlen[33:32] != 2'b00) begin
                                 phase_in = PH_ERR;
                              end else begin
                                 crem_in  = mlen[31:0];
                                 phase_in = PH_COPY;
                              end
                           end else begin
                              if (!off_ok(40'(loff_ff), wt_ff)) begin
                                 phase_in = PH_ERR;
                              end else begin
                                 crem_in  = acc_ff;
                                 phase_in = PH_COPY;
                              end
                           end
                        end
                        default: begin
                           acc_in = acc_sh;
                           if (acc_sh >= 32'd16) begin
                              if (noff != '0) begin
                                 if (32'(noff) > wt_ff) begin
                                    phase_in = PH_ERR;
                                    est_in   = ES_DONE;
                                 end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = hist_idx(wp_ff, OFF_W'(noff));
                                    est_in  = ES_READ;
                                 end
                              end else begin
                                 emit_en  = 1'b1;
                                 emit_val = '0;
                                 amf_in   = 1'b0;
                                 phase_in = PH_T0;
                              end
                           end
                        end
                     endcase
                  end
               end
               default: est_in = ES_DONE;
            endcase
         end
         ES_READ: begin
            emit_en  = 1'b1;
            emit_val = hist_q;
            est_in   = ES_RUN;
            if (phase_ff == PH_COPY) begin
               crem_in = crem_ff - 32'd1;
            end else begin
               amf_in   = 1'b0;
               phase_in = PH_T0;
            end
         end
         ES_DONE: est_in = ES_IDLE;
         default: est_in = ES_IDLE;
      endcase
      if (emit_en) begin
         wp_in = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         wt_in = wt_next;
         if (!burst_full) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      item_pop    = (est_ff == ES_IDLE) && item_valid && !emit_busy;
      hand.valid  = (est_ff == ES_DONE);
      hand.status = phase_status(phase_ff);
      hand.total  = wt_ff;
      hand_count  = cnt_ff;
      bw_en       = emit_en && !burst_full;
      bw_addr     = cnt_ff[BW-1:0];
      bw_byte     = emit_val;
      bw_total    = wt_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff   <= ES_IDLE;
         phase_ff <= PH_FIRST;
         wp_ff    <= '0;
         wt_ff    <= '0;
         tag_ff   <= '0;
         tbi_ff   <= 4'd8;
         amf_ff   <= 1'b0;
         loff_ff  <= '0;
         acc_ff   <= '0;
         crem_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         est_ff   <= est_in;
         phase_ff <= phase_in;
         wp_ff    <= wp_in;
         wt_ff    <= wt_in;
         tag_ff   <= tag_in;
         tbi_ff   <= tbi_in;
         amf_ff   <= amf_in;
         loff_ff  <= loff_in;
         acc_ff   <= acc_in;
         crem_ff  <= crem_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         hist_mem[wp_ff] <= emit_val;
      end
      if (rd_en) begin
         hist_q <= hist_mem[rd_addr];
      end
   end

   a_read_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (est_ff == ES_READ) |-> $past(rd_en))
      else $error("history data consumed without a read");

   a_pop_only_unused_act: assert property (@(posedge clock) disable iff (reset)
      (est_ff == ES_TAKE) |-> (act_ff == ACT_BYTE))
      else $error("byte taken for a non-byte transaction");

   a_no_emit_when_done: assert property (@(posedge clock) disable iff (reset)
      emit_en |-> !done && !emit_busy)
      else $error("byte emitted after end or while results drain");

endmodule

>>> rtl/lzgd_emit.sv
// ----------------------------------------------------------------------------
// lzgd_emit
// Burst buffer and result register; drains one transaction's bytes once its
// status is known.
// ----------------------------------------------------------------------------
module lzgd_emit #(
   parameter int MAX_BURST = lzgd_pkg::MAX_BURST_DEF,
   parameter int CW        = $clog2(MAX_BURST + 1),
   parameter int BW        = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  lzgd_pkg::hand_type hand,
   input  logic [CW-1:0]      hand_count,
   output logic               emit_busy,
   input  logic               bw_en,
   input  logic [BW-1:0]      bw_addr,
   input  logic [7:0]         bw_byte,
   input  logic [31:0]        bw_total,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_total_out,
   output logic               rsp_last
);
   import lzgd_pkg::*;

   emit_state_type ms_ff, ms_in;
   logic [39:0]    bmem [MAX_BURST];
   logic [39:0]    bq;
   logic           b_re;
   logic [BW-1:0]  b_ra;
   logic [CW-1:0]  cnt_ff, cnt_in, idx_ff, idx_in;
   logic [CW-1:0]  idx_nx;
   status_type     st_ff, st_in;
   logic           vld_ff, vld_in, last_ff, last_in, bv_ff, bv_in;
   logic [7:0]     ob_ff, ob_in;
   logic [31:0]    tot_ff, tot_in;

   assign idx_nx = idx_ff + 1'b1;

   always_comb begin
      ms_in = ms_ff;
      case (ms_ff)
         MS_IDLE: begin
            if (hand.valid) begin
               ms_in = (hand_count == '0) ? MS_SHOW : MS_READ;
            end
         end
         MS_READ: ms_in = MS_SHOW;
         MS_SHOW: begin
            if (rsp_ready) begin
               ms_in = last_ff ? MS_IDLE : MS_READ;
            end
         end
         default: ms_in = MS_IDLE;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      st_in   = st_ff;
      vld_in  = vld_ff;
      last_in = last_ff;
      bv_in   = bv_ff;
      ob_in   = ob_ff;
      tot_in  = tot_ff;
      b_re    = 1'b0;
      b_ra    = idx_ff[BW-1:0];
      case (ms_ff)
         MS_IDLE: begin
            if (hand.valid) begin
               cnt_in = hand_count;
               st_in  = hand.status;
               idx_in = '0;
               if (hand_count == '0) begin
                  vld_in  = 1'b1;
                  bv_in   = 1'b0;
                  ob_in   = '0;
                  tot_in  = hand.total;
                  last_in = 1'b1;
               end else begin
                  b_re = 1'b1;
                  b_ra = '0;
               end
            end
         end
         MS_READ: begin
            vld_in  = 1'b1;
            bv_in   = 1'b1;
            ob_in   = bq[39:32];
            tot_in  = bq[31:0];
            last_in = (idx_nx == cnt_ff);
         end
         MS_SHOW: begin
            if (rsp_ready) begin
               vld_in = 1'b0;
               if (!last_ff) begin
                  idx_in = idx_nx;
                  b_re   = 1'b1;
                  b_ra   = idx_nx[BW-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign emit_busy      = (ms_ff != MS_IDLE);
   assign rsp_valid      = vld_ff;
   assign rsp_out_byte   = ob_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_status     = st_ff;
   assign rsp_total_out  = tot_ff;
   assign rsp_last       = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff  <= MS_IDLE;
         vld_ff <= 1'b0;
      end else begin
         ms_ff  <= ms_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      st_ff   <= st_in;
      last_ff <= last_in;
      bv_ff   <= bv_in;
      ob_ff   <= ob_in;
      tot_ff  <= tot_in;
   end

   always_ff @(posedge clock) begin
      if (bw_en) begin
         bmem[bw_addr] <= {bw_byte, bw_total};
      end
      if (b_re) begin
         bq <= bmem[b_ra];
      end
   end

   a_hand_when_idle: assert property (@(posedge clock) disable iff (reset)
      hand.valid |-> (ms_ff == MS_IDLE) && !bw_en)
      else $error("handoff while results still drain");

   a_show_has_valid: assert property (@(posedge clock) disable iff (reset)
      (ms_ff == MS_SHOW) |-> vld_ff)
      else $error("result stage without a valid result");

endmodule

>>> rtl/lz_gamma_depacker_top.sv
// ----------------------------------------------------------------------------
// lz_gamma_depacker_top
// LZ depacker with tag bits and gamma-coded lengths, one compressed byte per
// input transaction, up to MAX_BURST decompressed bytes per transaction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    action, data_byte
//  rsp      out        rsp_valid/rsp_ready    out_byte, byte_valid, status,
//                                             total_out, last
//
//  A dropped or stream-start transaction goes from idle straight to done to hand over its result.
//  A taken byte adds a take step, each tag bit a run step, and each copied or
//  nibble byte a run and a read step, since every history read is registered
//  first. Results then drain from the burst buffer, each byte through a read
//  and a show state. Reset clears the decode state; the history memory needs
//  no clearing. A two-entry input queue accepts while results wait on rsp_ready, until it is full.
// ----------------------------------------------------------------------------
module lz_gamma_depacker_top #(
   parameter int HISTORY_DEPTH = lzgd_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_BURST     = lzgd_pkg::MAX_BURST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_total_out,
   output logic        rsp_last
);
   import lzgd_pkg::*;

   localparam int CW = $clog2(MAX_BURST + 1);
   localparam int BW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

   logic          item_valid, item_pop, emit_busy, bw_en;
   item_type      item;
   hand_type      hand;
   logic [CW-1:0] hand_count;
   logic [BW-1:0] bw_addr;
   logic [7:0]    bw_byte;
   logic [31:0]   bw_total;

   lzgd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_data_byte,
      .item_valid, .item, .item_pop
   );

   lzgd_engine #(
      .HISTORY_DEPTH(HISTORY_DEPTH), .MAX_BURST(MAX_BURST), .CW(CW), .BW(BW)
   ) u_engine (
      .clock, .reset, .item_valid, .item, .item_pop, .emit_busy, .hand,
      .hand_count, .bw_en, .bw_addr, .bw_byte, .bw_total
   );

   lzgd_emit #(.MAX_BURST(MAX_BURST), .CW(CW), .BW(BW)) u_emit (
      .clock, .reset, .hand, .hand_count, .emit_busy, .bw_en, .bw_addr,
      .bw_byte, .bw_total, .rsp_valid, .rsp_ready, .rsp_out_byte,
      .rsp_byte_valid, .rsp_status, .rsp_total_out, .rsp_last
   );

endmodule
